/* rtl/core/gtps_pkg.sv */
// gtps_pkg: shared types, widths and constants for the go-to-pose steering block
// used by every module under rtl/core; no dependencies of its own

package gtps_pkg;

   // field widths
   localparam int COORD_W = 12;
   localparam int HEAD_W  = 13;
   localparam int OFS_W   = 13;
   localparam int VEC_W   = 26;
   localparam int ANG_W   = 27;
   localparam int SQ_W    = 26;
   localparam int ROOT_W  = 13;
   localparam int TOT_W   = 28;
   localparam int DIR_W   = 9;
   localparam int TURN_W  = 10;
   localparam int TOL_W   = 12;
   localparam int TOLSQ_W = 24;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HDG = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_TOL = 2'd3;
   localparam logic [TOL_W-1:0]     ARRIVE_TOL_RESET = 12'd32;

   // cordic and square root step counts, and the start vector shift
   localparam int TABLE_LEN  = 24;
   localparam int SQRT_STEPS = 13;
   localparam int VEC_SHIFT  = 10;

   // angles in 1/65536 degree
   localparam logic signed [ANG_W-1:0] ANG_HALF    = 27'sd11796480;
   localparam logic signed [TOT_W-1:0] ANG_QUARTER = 28'sd5898240;

   // item handed along the chain of cells
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic [SQ_W-1:0]         rem;
      logic [SQ_W-1:0]         root;
      logic [SQ_W-1:0]         sq;
      logic [HEAD_W-1:0]       heading;
      logic                    zero;
   } gtps_item_type;

   // arctangent of 2^-i in 1/65536 degree, rounded
   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic signed [ANG_W-1:0] v;
      begin
         case (idx)
            0:  v = 27'sd2949120;
            1:  v = 27'sd1740967;
            2:  v = 27'sd919879;
            3:  v = 27'sd466945;
            4:  v = 27'sd234379;
            5:  v = 27'sd117305;
            6:  v = 27'sd58666;
            7:  v = 27'sd29335;
            8:  v = 27'sd14668;
            9:  v = 27'sd7334;
            10: v = 27'sd3667;
            11: v = 27'sd1833;
            12: v = 27'sd917;
            13: v = 27'sd458;
            14: v = 27'sd229;
            15: v = 27'sd115;
            16: v = 27'sd57;
            17: v = 27'sd29;
            18: v = 27'sd14;
            19: v = 27'sd7;
            20: v = 27'sd4;
            21: v = 27'sd2;
            22: v = 27'sd1;
            default: v = 27'sd0;
         endcase
         return v;
      end
   endfunction

endpackage

/* rtl/core/gtps_prep.sv */
// gtps_prep: two front stages, target offset then squared length and vector set-up
// depends on gtps_pkg

module gtps_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gtps_pkg::COORD_W-1:0]  target_x,
   input  logic [gtps_pkg::COORD_W-1:0]  target_y,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic [gtps_pkg::COORD_W-1:0]  pos_x,
   input  logic [gtps_pkg::COORD_W-1:0]  pos_y,
   input  logic [gtps_pkg::HEAD_W-1:0]   pos_heading,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output gtps_pkg::gtps_item_type       dn_item
);
   import gtps_pkg::*;

   logic                    a_valid_ff;
   logic signed [OFS_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [HEAD_W-1:0]       ph_ff;
   logic                    a_ready;

   logic                    b_valid_ff;
   gtps_item_type           item_ff, item_in;
   logic                    b_ready;

   logic signed [SQ_W-1:0]  dx2, dy2;
   logic signed [VEC_W-1:0] xe, ye;
   logic                    neg;

   // stage handshakes, a stage moves when empty or its successor moves
   assign b_ready  = !b_valid_ff || dn_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;
   assign dn_valid = b_valid_ff;
   assign dn_item  = item_ff;

   // offset from measured position to target
   assign dx_in = $signed({1'b0, target_x}) - $signed({1'b0, pos_x});
   assign dy_in = $signed({1'b0, target_y}) - $signed({1'b0, pos_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= up_valid;
      end
      if (up_valid && a_ready) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         ph_ff <= pos_heading;
      end
   end

   // squared length and folded start vector for the cordic
   always_comb begin
      dx2 = SQ_W'(dx_ff) * SQ_W'(dx_ff);
      dy2 = SQ_W'(dy_ff) * SQ_W'(dy_ff);
      neg = dx_ff[OFS_W-1];
      xe  = neg ? -VEC_W'(dx_ff) : VEC_W'(dx_ff);
      ye  = neg ? -VEC_W'(dy_ff) : VEC_W'(dy_ff);
      item_in.x       = xe <<< VEC_SHIFT;
      item_in.y       = ye <<< VEC_SHIFT;
      item_in.z       = neg ? ANG_HALF : '0;
      item_in.sq      = SQ_W'($unsigned(dx2)) + SQ_W'($unsigned(dy2));
      item_in.rem     = item_in.sq;
      item_in.root    = '0;
      item_in.heading = ph_ff;
      item_in.zero    = (dx_ff == '0) && (dy_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (a_valid_ff && b_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/core/gtps_cell.sv */
// gtps_cell: one link of the chain, a cordic vectoring step if ROTATE and a root digit if SQRT_ON
// depends on gtps_pkg

module gtps_cell #(
   parameter int INDEX  = 0,
   parameter bit ROTATE = 1'b1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  gtps_pkg::gtps_item_type up_item,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output gtps_pkg::gtps_item_type dn_item
);
   import gtps_pkg::*;

   localparam bit SQRT_ON  = (INDEX < SQRT_STEPS);
   localparam int SQ_SHIFT = SQRT_ON ? 2 * (SQRT_STEPS - 1 - INDEX) : 0;
   localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << SQ_SHIFT;
   localparam logic signed [ANG_W-1:0] ATAN = atan_entry(INDEX);

   logic                    valid_ff;
   gtps_item_type           item_ff, item_in;
   logic signed [VEC_W-1:0] xs, ys;
   logic [SQ_W-1:0]         trial;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

   // rotate toward the x axis if ROTATE, then try the next root bit if SQRT_ON
   always_comb begin
      item_in = up_item;
      xs      = up_item.x >>> INDEX;
      ys      = up_item.y >>> INDEX;
      trial   = up_item.root + SQ_BIT;
      if (ROTATE) begin
         if (!up_item.y[VEC_W-1]) begin
            item_in.x = up_item.x + ys;
            item_in.y = up_item.y - xs;
            item_in.z = up_item.z + ATAN;
         end else begin
            item_in.x = up_item.x - ys;
            item_in.y = up_item.y + xs;
            item_in.z = up_item.z - ATAN;
         end
      end
      if (SQRT_ON) begin
         if (up_item.rem >= trial) begin
            item_in.rem  = up_item.rem - trial;
            item_in.root = (up_item.root >> 1) + SQ_BIT;
         end else begin
            item_in.root = up_item.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_valid && up_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/core/gtps_finish.sv */
// gtps_finish: last stage, direction and turn in degrees, arrival test, output register
// depends on gtps_pkg

module gtps_finish (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [gtps_pkg::HEAD_W-1:0]         target_heading,
   input  logic [gtps_pkg::TOL_W-1:0]          arrive_tolerance,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  gtps_pkg::gtps_item_type             up_item,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gtps_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import gtps_pkg::*;

   // whole degrees of a heading, shifted by half a turn and wrapped
   function automatic logic [DIR_W-1:0] wrap_heading(input logic [HEAD_W-1:0] h);
      logic [DIR_W:0] d;
      begin
         d = {1'b0, h[HEAD_W-1:4]} + 10'd180;
         if (d >= 10'd360) begin
            d = d - 10'd360;
         end
         return d[DIR_W-1:0];
      end
   endfunction

   logic                     valid_ff;
   logic [RSP_DATA_W-1:0]    data_ff, data_in;
   logic [TOLSQ_W-1:0]       tol_sq_ff;

   logic signed [ANG_W-1:0]  ang;
   logic signed [TOT_W-1:0]  total;
   logic signed [11:0]       deg, deg_w;
   logic [DIR_W-1:0]         tf, tc;
   logic signed [TURN_W-1:0] turn;
   logic                     arrived;

   assign up_ready   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   // squared tolerance, follows the register
   always_ff @(posedge clock) begin
      tol_sq_ff <= TOLSQ_W'(arrive_tolerance) * TOLSQ_W'(arrive_tolerance);
   end

   // direction: angle minus heading plus a quarter turn, floored and wrapped
   always_comb begin
      ang   = up_item.zero ? '0 : up_item.z;
      total = TOT_W'(ang) - $signed({3'b000, up_item.heading, 12'h000}) + ANG_QUARTER;
      deg   = total[TOT_W-1:16];
      deg_w = deg;
      if (deg < 0) begin
         deg_w = deg + 12'sd360;
         if (deg_w < 0) begin
            deg_w = deg_w + 12'sd360;
         end
      end else if (deg >= 12'sd360) begin
         deg_w = deg - 12'sd360;
      end
      tf      = wrap_heading(target_heading);
      tc      = wrap_heading(up_item.heading);
      turn    = $signed({1'b0, tc}) - $signed({1'b0, tf});
      arrived = ({2'b00, tol_sq_ff} >= up_item.sq);
      data_in = {7'b0, arrived, up_item.root[ROOT_W-1:0], turn, deg_w[DIR_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/core/go_to_pose_steering.sv */
// go_to_pose_steering: top level, configuration registers and the chain of cells
// depends on gtps_pkg, gtps_prep, gtps_cell and gtps_finish
//
// Usage: each transaction on the req_ channel carries one measured pose
// (x, y in 1/32 inch, heading in 1/16 degree). For each one exactly one
// transaction leaves on the rsp_ channel with the drive direction (0..359
// degrees, relative to the robot), the turn rate in whole degrees, the
// distance to the target and the arrived flag, in the order taken in.
// The target pose and arrival radius are written through the csr_ port;
// the user must write them only while no pose is in flight; the block has no guard for it.
// A request passes the offset and set-up stages, N cells and the output
// register, N being the larger of min(CORDIC_STEPS, 24) and 13.
// Throughput: one pose per cycle while rsp_tready stays high; each cell
// does a cordic step if ROTATE, a root digit if SQRT_ON, and hands it on.
// Reset clears all stage valid flags and loads the registers with target 0,
// heading 0 and a radius of 32. When the receiver stalls the finished
// response waits in the output register while the chain closes up its
// gaps; req_tready falls only once every stage holds a pose.

module go_to_pose_steering #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // pos_x [11:0], pos_y [23:12], pos_heading [36:24]
   input  logic [gtps_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // drive_direction [8:0], turn_rate [18:9], distance_error [31:19], arrived [32]
   output logic [gtps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [gtps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gtps_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gtps_pkg::*;

   localparam int STEPS_EFF = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam int NUM_CELLS = (STEPS_EFF > SQRT_STEPS) ? STEPS_EFF : SQRT_STEPS;

   logic [COORD_W-1:0] target_x_ff;
   logic [COORD_W-1:0] target_y_ff;
   logic [HEAD_W-1:0]  target_heading_ff;
   logic [TOL_W-1:0]   arrive_tol_ff;

   logic          link_valid [NUM_CELLS+1];
   logic          link_ready [NUM_CELLS+1];
   gtps_item_type link_item  [NUM_CELLS+1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff       <= '0;
         target_y_ff       <= '0;
         target_heading_ff <= '0;
         arrive_tol_ff     <= ARRIVE_TOL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_X:   target_x_ff       <= csr_wdata[COORD_W-1:0];
            CSR_TARGET_Y:   target_y_ff       <= csr_wdata[COORD_W-1:0];
            CSR_TARGET_HDG: target_heading_ff <= csr_wdata[HEAD_W-1:0];
            CSR_ARRIVE_TOL: arrive_tol_ff     <= csr_wdata[TOL_W-1:0];
         endcase
      end
   end

   // offset, squared length and start vector
   gtps_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .target_x    (target_x_ff),
      .target_y    (target_y_ff),
      .up_valid    (req_tvalid),
      .up_ready    (req_tready),
      .pos_x       (req_tdata[11:0]),
      .pos_y       (req_tdata[23:12]),
      .pos_heading (req_tdata[36:24]),
      .dn_valid    (link_valid[0]),
      .dn_ready    (link_ready[0]),
      .dn_item     (link_item[0])
   );

   // chain of cells
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      gtps_cell #(
         .INDEX  (i),
         .ROTATE (i < STEPS_EFF)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[i]),
         .up_ready (link_ready[i]),
         .up_item  (link_item[i]),
         .dn_valid (link_valid[i+1]),
         .dn_ready (link_ready[i+1]),
         .dn_item  (link_item[i+1])
      );
   end

   // result formatting and output register
   gtps_finish u_finish (
      .clock            (clock),
      .reset            (reset),
      .target_heading   (target_heading_ff),
      .arrive_tolerance (arrive_tol_ff),
      .up_valid         (link_valid[NUM_CELLS]),
      .up_ready         (link_ready[NUM_CELLS]),
      .up_item          (link_item[NUM_CELLS]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

endmodule

/* tb/sv/tb_go_to_pose_steering.sv */
// tb_go_to_pose_steering: self-checking testbench for the go-to-pose steering block
// depends on gtps_pkg and go_to_pose_steering; predicts every response with its own
// cordic and square-root model and checks responses in order on the rsp_ stream

module tb_go_to_pose_steering;
   import gtps_pkg::*;

   localparam int CORDIC_STEPS = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 32;
   localparam longint ANG_UNIT = 65536;
   localparam longint ANG_TURN = 360 * 65536;

   // arctangent of 2^-i in 1/65536 degree, rounded
   localparam int CORDIC_ATAN [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic [8:0]        dir;
      logic signed [9:0] turn;
      logic [12:0]       distance;
      logic              arrived;
   } steer_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // local copy of the target registers
   logic [11:0] tgt_x;
   logic [11:0] tgt_y;
   logic [12:0] tgt_hdg;
   logic [11:0] arrive_tol;

   steer_type steer_expect [$];

   int  mismatches = 0;
   int  poses_sent = 0;
   int  responses_checked = 0;
   int  arrivals_seen = 0;
   int  input_stall_cycles = 0;
   int  cycle_count = 0;
   bit  tx_no_idle = 0;
   bit  rx_no_idle = 0;
   int  hold_request = 0;
   int  hold_left = 0;

   go_to_pose_steering #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor of the square root, one bit at a time
   function automatic longint floor_sqrt(input longint n);
      longint r;
      longint t;
      int     b;
      r = 0;
      for (b = 13; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= n)
            r = t;
      end
      return r;
   endfunction

   // steering command for one pose against the current target
   function automatic steer_type predict_steering(input logic [11:0] px,
                                                  input logic [11:0] py,
                                                  input logic [12:0] ph);
      longint dx, dy, sq, x, y, z, xs, ys, total, hdg, tf, tc, turn, tol;
      int     i;
      steer_type r;
      dx = tgt_x;
      dx = dx - longint'(px);
      dy = tgt_y;
      dy = dy - longint'(py);
      hdg = ph;
      tol = arrive_tol;
      sq = dx * dx + dy * dy;

      // vectoring cordic, left half folded over by 180 degrees
      z = 0;
      if (dx != 0 || dy != 0) begin
         if (dx < 0) begin
            x = -dx;
            y = -dy;
            z = 180 * ANG_UNIT;
         end else begin
            x = dx;
            y = dy;
         end
         x = x * 1024;
         y = y * 1024;
         for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + CORDIC_ATAN[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - CORDIC_ATAN[i];
            end
         end
      end

      total = z - hdg * 4096 + 90 * ANG_UNIT;
      total = total % ANG_TURN;
      if (total < 0)
         total = total + ANG_TURN;

      tf = (longint'(tgt_hdg) / 16 + 180) % 360;
      tc = (hdg / 16 + 180) % 360;
      turn = tc - tf;

      r.dir      = 9'(total / ANG_UNIT);
      r.turn     = turn[9:0];
      r.distance = 13'(floor_sqrt(sq));
      r.arrived  = (sq <= tol * tol);
      return r;
   endfunction

   // write all four target registers back to back, values 13 bits wide
   task automatic load_target(input logic [12:0] x, input logic [12:0] y,
                              input logic [12:0] h, input logic [12:0] tol);
      csr_we    <= 1'b1;
      csr_index <= CSR_TARGET_X;
      csr_wdata <= x;
      @(negedge clock);
      csr_index <= CSR_TARGET_Y;
      csr_wdata <= y;
      @(negedge clock);
      csr_index <= CSR_TARGET_HDG;
      csr_wdata <= h;
      @(negedge clock);
      csr_index <= CSR_ARRIVE_TOL;
      csr_wdata <= tol;
      @(negedge clock);
      csr_we <= 1'b0;
      tgt_x      = x[11:0];
      tgt_y      = y[11:0];
      tgt_hdg    = h;
      arrive_tol = tol[11:0];
      @(negedge clock);
   endtask

   // offer one pose, after a random gap unless tx_no_idle, and log its prediction on acceptance
   task automatic send_pose(input logic [11:0] x, input logic [11:0] y, input logic [12:0] h);
      if (!tx_no_idle) begin
         while ($urandom_range(99) < 25) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tdata  <= {3'b000, h, y, x};
      req_tvalid <= 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      steer_expect.push_back(predict_steering(x, y, h));
      poses_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding response
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (steer_expect.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [11:0] clamp_coord(input int v);
      if (v < 0)
         return 12'd0;
      if (v > 4095)
         return 12'd4095;
      return 12'(v);
   endfunction

   // mostly uniform poses, plus poses near or on the target, on its axes and at corners
   task automatic random_pose(output logic [11:0] x, output logic [11:0] y,
                              output logic [12:0] h);
      int kind;
      int v;
      kind = $urandom_range(99);
      if (kind < 55) begin
         x = 12'($urandom);
         y = 12'($urandom);
      end else if (kind < 78) begin
         v = $urandom_range(128);
         x = clamp_coord(int'(tgt_x) + v - 64);
         v = $urandom_range(128);
         y = clamp_coord(int'(tgt_y) + v - 64);
      end else if (kind < 88) begin
         x = ($urandom_range(1) == 1) ? tgt_x : 12'($urandom);
         y = (x == tgt_x) ? 12'($urandom) : tgt_y;
      end else if (kind < 93) begin
         x = tgt_x;
         y = tgt_y;
      end else begin
         x = ($urandom_range(1) == 1) ? 12'd4095 : 12'd0;
         y = ($urandom_range(1) == 1) ? 12'd4095 : 12'd0;
      end
      kind = $urandom_range(99);
      if (kind < 75)
         h = 13'($urandom_range(5759));
      else if (kind < 88)
         h = 13'($urandom_range(8191, 5760));
      else
         h = {tgt_hdg[12:4], 4'($urandom)};
   endtask

   // pick a new target: random, all zero, all ones, or with a tight radius
   task automatic random_target();
      int mode;
      logic [12:0] x, y, h, tol;
      mode = $urandom_range(9);
      x = 13'($urandom);
      y = 13'($urandom);
      h = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(5759));
      tol = ($urandom_range(1) == 1) ? 13'($urandom_range(300)) : 13'($urandom);
      if ($urandom_range(1) == 1)
         tol[12] = 1'b1;
      if (mode == 0) begin
         x = '0;
         y = '0;
         h = '0;
         tol = '0;
      end else if (mode == 1) begin
         x = '1;
         y = '1;
         h = '1;
         tol = '1;
      end else if (mode == 2) begin
         tol = 13'($urandom_range(3));
      end
      load_target(x, y, h, tol);
   endtask

   task automatic send_random_poses(input int count);
      logic [11:0] x, y;
      logic [12:0] h;
      repeat (count) begin
         random_pose(x, y, h);
         send_pose(x, y, h);
      end
   endtask

   // reset target: origin, heading zero, radius 32
   task automatic test_reset_defaults();
      send_pose(12'd0, 12'd0, 13'd0);          // zero offset
      send_pose(12'd4095, 12'd4095, 13'd5759); // longest offset, top heading
      send_pose(12'd20, 12'd0, 13'd0);         // offset along negative x
      send_pose(12'd0, 12'd4095, 13'h1FFF);    // heading beyond the valid range
      send_pose(12'd24, 12'd18, 13'd16);       // inside the radius
      send_pose(12'd32, 12'd0, 13'd8);         // exactly on the radius
      send_pose(12'd32, 12'd1, 13'd8);         // just outside
      wait_until_drained();
   endtask

   // extremes of every register, masking of over-wide writes
   task automatic test_directed_extremes();
      load_target(13'd4095, 13'd4095, 13'd5759, 13'd4095);
      send_pose(12'd0, 12'd0, 13'd0);          // diagonal, outside the radius
      send_pose(12'd4095, 12'd0, 13'd2880);    // exactly on the largest radius
      send_pose(12'd4095, 12'd4095, 13'd5759); // on target, turn zero
      send_pose(12'd4095, 12'd0, 13'd5743);    // offset along positive y
      send_pose(12'd0, 12'd4095, 13'd1440);    // offset along positive x
      send_pose(12'd4095, 12'd4095, 13'd15);
      wait_until_drained();
      // upper bits of the 12-bit registers are dropped
      load_target(13'h1FFF, 13'h1000, 13'h1FFF, 13'h1000);
      send_pose(12'd4095, 12'd0, 13'h1FFF);    // on target with zero radius
      send_pose(12'd4094, 12'd0, 13'd0);
      send_pose(12'd0, 12'd1, 13'd100);
      send_pose(12'd4095, 12'd4095, 13'd5760);
      send_pose(12'd2048, 12'd2048, 13'd2880);
      wait_until_drained();
   endtask

   // random phases, each with a fresh target
   task automatic test_random_poses();
      repeat (7) begin
         random_target();
         send_random_poses(105);
         wait_until_drained();
      end
   endtask

   // both sides without gaps
   task automatic test_back_to_back();
      random_target();
      tx_no_idle = 1;
      rx_no_idle = 1;
      send_random_poses(150);
      wait_until_drained();
      tx_no_idle = 0;
      rx_no_idle = 0;
   endtask

   // receiver holds off long enough for the chain to fill and stall the input
   task automatic test_output_stall();
      random_target();
      tx_no_idle = 1;
      hold_request = 80;
      send_random_poses(60);
      tx_no_idle = 0;
      wait_until_drained();
      send_random_poses(20);
      wait_until_drained();
   endtask

   // receiver ready with random gaps unless rx_no_idle, and an occasional long hold-off
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (rx_no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 25);
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      steer_type got;
      steer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.dir      = rsp_tdata[8:0];
         got.turn     = rsp_tdata[18:9];
         got.distance = rsp_tdata[31:19];
         got.arrived  = rsp_tdata[32];
         if (steer_expect.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response: dir %0d turn %0d distance %0d arrived %0d",
                        got.dir, got.turn, got.distance, got.arrived);
            mismatches++;
         end else begin
            want = steer_expect.pop_front();
            if (got.dir !== want.dir || got.turn !== want.turn ||
                got.distance !== want.distance || got.arrived !== want.arrived) begin
               if (mismatches < 10)
                  $display({"response %0d: expected dir %0d turn %0d distance %0d ",
                            "arrived %0d, got dir %0d turn %0d distance %0d arrived %0d"},
                           responses_checked, want.dir, want.turn, want.distance,
                           want.arrived, got.dir, got.turn, got.distance, got.arrived);
               mismatches++;
            end
            if (want.arrived)
               arrivals_seen++;
         end
         responses_checked++;
      end
   end

   // cycle limit and input stall count
   always @(posedge clock) begin
      cycle_count++;
      if (req_tvalid && !req_tready && !reset)
         input_stall_cycles++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_TARGET_X;
      csr_wdata  = '0;
      tgt_x      = '0;
      tgt_y      = '0;
      tgt_hdg    = '0;
      arrive_tol = ARRIVE_TOL_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_directed_extremes();
      test_random_poses();
      test_back_to_back();
      test_output_stall();

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      mismatches = mismatches + steer_expect.size();

      $display("%0d poses over 12 target settings, %0d responses checked, %0d arrivals",
               poses_sent, responses_checked, arrivals_seen);
      $display("input held off for %0d cycles in total, %0d mismatches",
               input_stall_cycles, mismatches);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/gtps_pkg.sv
rtl/core/gtps_prep.sv
rtl/core/gtps_cell.sv
rtl/core/gtps_finish.sv
rtl/core/go_to_pose_steering.sv
tb/sv/tb_go_to_pose_steering.sv
